### hw/rtl/i2cseq_pkg.sv
// ----------------------------------------------------------------------------
// I2C register transfer sequencer package
// Shared constants, codes and structures for the sequencer and its step logic.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

    // Queue depths and derived widths
    localparam int TX_DEPTH   = 4;
    localparam int RX_DEPTH   = 32;
    localparam int TX_IDX_W   = $clog2(TX_DEPTH);
    localparam int TX_CNT_W   = 3;
    localparam int RX_CNT_W   = 6;
    localparam int RX_IDX_W   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_LENGTH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_LENGTH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_BYTES       = 3'd4;

    // Transaction phase
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_WRITE     = 3'd1,
        PH_WRITE_END = 3'd2,
        PH_READ_PTR  = 3'd3,
        PH_READ_DATA = 3'd4,
        PH_READ_END  = 3'd5
    } t_phase;

    // Bus event codes
    typedef enum logic [2:0] {
        ACT_BEGIN       = 3'd0,
        ACT_MODE_SEL    = 3'd1,
        ACT_TX_SEL      = 3'd2,
        ACT_TX_BUSY     = 3'd3,
        ACT_TX_DONE     = 3'd4,
        ACT_RX_SEL      = 3'd5,
        ACT_RX_BYTE     = 3'd6,
        ACT_OTHER       = 3'd7
    } t_action;

    // Configuration register file
    typedef struct packed {
        logic [6:0]          device_address;
        logic                transfer_mode;
        logic [2:0]          tx_length;
        logic [5:0]          rx_length;
        logic [31:0]         tx_bytes;
    } t_cfg;

    // Sequencer state
    typedef struct packed {
        t_phase              phase;
        logic [TX_CNT_W-1:0] sent_count;
        logic [RX_CNT_W-1:0] received_count;
    } t_seq_state;

    // One command word
    typedef struct packed {
        logic                send_address;
        logic [7:0]          address_byte;
        logic                send_data;
        logic [7:0]          data_byte;
        logic                make_start;
        logic                make_stop;
        logic                ack_off;
        logic                buffer_irq_off;
        logic                all_irq_off;
        logic                store_valid;
        logic [RX_IDX_W-1:0] store_index;
        logic [7:0]          store_data;
    } t_result;

endpackage

### hw/rtl/i2cseq_step.sv
// ----------------------------------------------------------------------------
// I2C sequencer step logic
// Decodes one bus event against the current phase and counts, and gives the
// next state together with the command word for that event.
// ----------------------------------------------------------------------------
module i2cseq_step (
    input  i2cseq_pkg::t_cfg       i_cfg,
    input  i2cseq_pkg::t_seq_state i_state,
    input  logic [2:0]             i_action,
    input  logic [7:0]             i_rx_byte,
    output i2cseq_pkg::t_seq_state o_state_next,
    output i2cseq_pkg::t_result    o_result
);
    import i2cseq_pkg::*;

    t_action               action;
    logic                  writing;
    logic                  reading;
    logic [TX_CNT_W-1:0]   tx_used;
    logic [RX_CNT_W-1:0]   rx_used;
    logic                  tx_left;
    logic [TX_CNT_W-1:0]   sent_inc;
    logic [RX_CNT_W-1:0]   received_inc;
    logic                  rx_one_left;
    logic                  rx_done;
    logic [TX_IDX_W-1:0]   tx_idx;

    // Decode phase and clamp lengths to the queue depths
    assign action   = t_action'(i_action);
    assign writing  = (i_state.phase == PH_WRITE);
    assign reading  = (i_state.phase == PH_READ_PTR) || (i_state.phase == PH_READ_DATA);
    assign tx_used  = (i_cfg.tx_length < TX_DEPTH) ? i_cfg.tx_length : TX_CNT_W'(TX_DEPTH);
    assign rx_used  = (i_cfg.rx_length < RX_DEPTH) ? i_cfg.rx_length : RX_CNT_W'(RX_DEPTH);

    // Count updates, saturating at the used lengths
    assign tx_left      = (i_state.sent_count < tx_used);
    assign sent_inc     = i_state.sent_count + TX_CNT_W'(1);
    assign tx_idx       = i_state.sent_count[TX_IDX_W-1:0];
    assign received_inc = (i_state.received_count < rx_used)
                          ? i_state.received_count + RX_CNT_W'(1)
                          : i_state.received_count;
    assign rx_one_left  = ({1'b0, received_inc} + (RX_CNT_W+1)'(1)) == {1'b0, rx_used};
    assign rx_done      = (received_inc >= rx_used);

    // Next state
    always_comb begin
        o_state_next = i_state;
        if (action == ACT_BEGIN) begin
            o_state_next.phase          = i_cfg.transfer_mode ? PH_READ_PTR : PH_WRITE;
            o_state_next.sent_count     = '0;
            o_state_next.received_count = '0;
        end else if (writing || reading) begin
            unique case (action)
                ACT_TX_SEL, ACT_TX_BUSY: begin
                    if (tx_left) begin
                        o_state_next.sent_count = sent_inc;
                        if (reading && (sent_inc == tx_used)) begin
                            o_state_next.phase = PH_READ_DATA;
                        end
                    end
                end
                ACT_TX_DONE: begin
                    if (writing) begin
                        o_state_next.phase = PH_WRITE_END;
                    end
                end
                ACT_RX_BYTE: begin
                    if (reading) begin
                        o_state_next.received_count = received_inc;
                        if (rx_done) begin
                            o_state_next.phase = PH_READ_END;
                        end
                    end
                end
                ACT_BEGIN, ACT_MODE_SEL, ACT_RX_SEL, ACT_OTHER: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Command word
    always_comb begin
        o_result = '0;
        if ((action != ACT_BEGIN) && (writing || reading)) begin
            unique case (action)
                ACT_MODE_SEL: begin
                    o_result.send_address = 1'b1;
                    o_result.address_byte = {i_cfg.device_address,
                                             i_state.phase == PH_READ_DATA};
                end
                ACT_TX_SEL, ACT_TX_BUSY: begin
                    if (tx_left) begin
                        o_result.send_data = 1'b1;
                        o_result.data_byte = i_cfg.tx_bytes[8*tx_idx +: 8];
                    end else if (writing) begin
                        o_result.buffer_irq_off = 1'b1;
                    end
                end
                ACT_TX_DONE: begin
                    if (writing) begin
                        o_result.make_stop   = 1'b1;
                        o_result.all_irq_off = 1'b1;
                    end else begin
                        o_result.make_start = 1'b1;
                    end
                end
                ACT_RX_SEL: begin
                    if (reading && (rx_used == RX_CNT_W'(1))) begin
                        o_result.ack_off   = 1'b1;
                        o_result.make_stop = 1'b1;
                    end
                end
                ACT_RX_BYTE: begin
                    if (reading) begin
                        o_result.store_valid = 1'b1;
                        o_result.store_index = i_state.received_count[RX_IDX_W-1:0];
                        o_result.store_data  = i_rx_byte;
                        if (rx_one_left) begin
                            o_result.ack_off   = 1'b1;
                            o_result.make_stop = 1'b1;
                        end
                        if (rx_done) begin
                            o_result.all_irq_off = 1'b1;
                        end
                    end
                end
                ACT_BEGIN, ACT_OTHER: begin
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### hw/rtl/i2c_master_register_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master register transfer sequencer
// Turns bus event words into I2C master commands for one register write or
// register read transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one bus event word: the
//   event code and, for a received byte, the byte itself.
//   Output channel (o_out_valid / i_out_ready) carries exactly one command
//   word per event word; an all-zero command means nothing is to be done.
//   Configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_data
//   while no word is in flight; indexes beyond the register list are ignored.
//   The command is registered and appears in the cycle after its event is accepted.
//   Throughput: one event per cycle unless stalled; the event decode and state
//   update sit in one combinational step in front of the command register.
//   A stalled receiver holds the command register; a new event is still
//   accepted in the cycle that the held command is taken.
//   Reset clears the phase to idle, both counts to zero, the output register
//   to empty and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [i2cseq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [i2cseq_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // event input
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [2:0]                          i_action,
    input  logic [7:0]                          i_rx_byte,
    // command output
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_send_address,
    output logic [7:0]                          o_address_byte,
    output logic                                o_send_data,
    output logic [7:0]                          o_data_byte,
    output logic                                o_make_start,
    output logic                                o_make_stop,
    output logic                                o_ack_off,
    output logic                                o_buffer_irq_off,
    output logic                                o_all_irq_off,
    output logic                                o_store_valid,
    output logic [i2cseq_pkg::RX_IDX_W-1:0]     o_store_index,
    output logic [7:0]                          o_store_data
);
    import i2cseq_pkg::*;

    t_cfg       r_cfg;
    t_seq_state r_state;
    t_seq_state n_state;
    t_result    r_result;
    t_result    n_result;
    logic       r_out_valid;
    logic       in_fire;

    // Accept a word whenever the command register is free or being drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= '0;
            r_cfg.transfer_mode  <= 1'b0;
            r_cfg.tx_length      <= 3'd1;
            r_cfg.rx_length      <= 6'd1;
            r_cfg.tx_bytes       <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DEVICE_ADDRESS: r_cfg.device_address <= i_cfg_data[6:0];
                CFG_TRANSFER_MODE:  r_cfg.transfer_mode  <= i_cfg_data[0];
                CFG_TX_LENGTH:      r_cfg.tx_length      <= i_cfg_data[2:0];
                CFG_RX_LENGTH:      r_cfg.rx_length      <= i_cfg_data[5:0];
                CFG_TX_BYTES:       r_cfg.tx_bytes       <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // Decode the event against the current state
    i2cseq_step u_step (
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .i_action     (i_action),
        .i_rx_byte    (i_rx_byte),
        .o_state_next (n_state),
        .o_result     (n_result)
    );

    // Advance state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= PH_IDLE;
            r_state.sent_count     <= '0;
            r_state.received_count <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Hold the command word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_send_address   = r_result.send_address;
    assign o_address_byte   = r_result.address_byte;
    assign o_send_data      = r_result.send_data;
    assign o_data_byte      = r_result.data_byte;
    assign o_make_start     = r_result.make_start;
    assign o_make_stop      = r_result.make_stop;
    assign o_ack_off        = r_result.ack_off;
    assign o_buffer_irq_off = r_result.buffer_irq_off;
    assign o_all_irq_off    = r_result.all_irq_off;
    assign o_store_valid    = r_result.store_valid;
    assign o_store_index    = r_result.store_index;
    assign o_store_data     = r_result.store_data;

`ifndef SYNTHESIS
    // Every accepted word leaves a command waiting in the next cycle
    a_fire_gives_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted word produced no command");

    // A begin word clears both counts
    a_begin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_action == ACT_BEGIN)) |=>
        (r_state.sent_count == '0) && (r_state.received_count == '0))
        else $error("begin did not clear the counts");

    // Counts never pass the queue depths
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.sent_count <= TX_DEPTH) && (r_state.received_count <= RX_DEPTH))
        else $error("transfer count beyond queue depth");

    // At most one of address, data and store per command
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0({r_result.send_address, r_result.send_data,
                                  r_result.store_valid}))
        else $error("command carries more than one byte kind");
`endif

endmodule
